// ===== sv/gbc_pkg.sv =====
package gbc_pkg;

  localparam int STEP_W = 6;

  localparam logic [1:0] OP_ENC  = 2'd0;
  localparam logic [1:0] OP_DEC  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam int ROT_AMOUNT = 11;

  // microprogram layout
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 6'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST    = 6'd1;
  localparam logic [STEP_W-1:0] STEP_LAST     = 6'd32;
  localparam logic [STEP_W-1:0] STEP_WB       = 6'd33;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_START,
    JC_OUTFREE,
    JC_GOTO
  } jump_t;

  typedef struct packed {
    jump_t             jc;
    logic [STEP_W-1:0] target;
    logic              round_en;
    logic              half_sel;
    logic [2:0]        key_enc;
    logic [2:0]        key_dec;
    logic              out_load;
  } uword_t;

  typedef struct packed {
    logic       load_blk;
    logic       load_row;
    logic       round_en;
    logic       half_sel;
    logic [2:0] key_idx;
    logic       out_load;
  } ctl_t;

  // control store: dispatch, 32 round steps, write-back
  function automatic uword_t ucode(input logic [STEP_W-1:0] a);
    uword_t     w;
    logic [4:0] r;
    w = '0;
    r = 5'(a - STEP_FIRST);
    if (a == STEP_DISPATCH) begin
      w.jc     = JC_START;
      w.target = STEP_FIRST;
    end else if (a >= STEP_FIRST && a <= STEP_LAST) begin
      w.jc       = JC_NEXT;
      w.round_en = 1'b1;
      w.half_sel = r[0];
      w.key_enc  = (r < 5'd24) ? r[2:0] : ~r[2:0];
      w.key_dec  = (r < 5'd8) ? r[2:0] : ~r[2:0];
    end else if (a == STEP_WB) begin
      w.jc       = JC_OUTFREE;
      w.target   = STEP_DISPATCH;
      w.out_load = 1'b1;
    end else begin
      w.jc     = JC_GOTO;
      w.target = STEP_DISPATCH;
    end
    return w;
  endfunction

endpackage

// ===== sv/gost_block_cipher_top.sv =====
// An accepted block runs through 32 round steps, then write-back, which
// may wait for the output register to be free.
// One block at a time (dispatch, 32 round steps, write-back); the single
// round unit does one round per cycle.
// S-box row loads and unused opcodes are taken at dispatch without leaving it.
// Reset (rst_n, synchronous, active low) clears key words, S-box rows,
// the step counter and the output valid flag.
module gost_block_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_block_in,
  input  logic [2:0]  in_row_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_block_out,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  gbc_pkg::ctl_t ctl;
  logic          in_fire;
  logic          out_free;
  logic [63:0]   result;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   block_out_r;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  gbc_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_opcode (in_opcode),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  gbc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_block_in   (in_block_in),
    .in_row_select (in_row_select),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .result        (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) block_out_r <= result;
  end

  assign out_valid     = out_valid_r;
  assign out_block_out = block_out_r;

  // busy for the whole round program after a block is taken
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_blk |=> !in_ready)
    else $error("input accepted during round program");

  a_wb_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_valid_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.out_load))
    else $error("output valid without write-back");

  a_no_round_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ctl.round_en && !ctl.out_load)
    else $error("datapath active while dispatching");

endmodule

// ===== sv/gbc_useq.sv =====
module gbc_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [1:0]          in_opcode,
  input  logic                out_free,
  output logic                in_ready,
  output gbc_pkg::ctl_t       ctl
);

  logic [gbc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       dec_r, dec_nxt;
  gbc_pkg::uword_t            uw;
  logic                       start;

  assign uw       = gbc_pkg::ucode(step_r);
  assign in_ready = (uw.jc == gbc_pkg::JC_START);
  assign start    = in_fire &&
                    (in_opcode == gbc_pkg::OP_ENC || in_opcode == gbc_pkg::OP_DEC);

  always_comb begin
    step_nxt = step_r;
    dec_nxt  = dec_r;
    case (uw.jc)
      gbc_pkg::JC_NEXT:    step_nxt = step_r + 1'b1;
      gbc_pkg::JC_START: begin
        if (start) begin
          step_nxt = uw.target;
          dec_nxt  = (in_opcode == gbc_pkg::OP_DEC);
        end
      end
      gbc_pkg::JC_OUTFREE: if (out_free) step_nxt = uw.target;
      gbc_pkg::JC_GOTO:    step_nxt = uw.target;
      default:             step_nxt = gbc_pkg::STEP_DISPATCH;
    endcase
  end

  always_comb begin
    ctl.load_blk = start;
    ctl.load_row = in_fire && (in_opcode == gbc_pkg::OP_LOAD);
    ctl.round_en = uw.round_en;
    ctl.half_sel = uw.half_sel;
    ctl.key_idx  = dec_r ? uw.key_dec : uw.key_enc;
    ctl.out_load = uw.out_load && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= gbc_pkg::STEP_DISPATCH;
      dec_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      dec_r  <= dec_nxt;
    end
  end

endmodule

// ===== sv/gbc_datapath.sv =====
module gbc_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  gbc_pkg::ctl_t ctl,
  input  logic [63:0]   in_block_in,
  input  logic [2:0]    in_row_select,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_index,
  input  logic [31:0]   cfg_wdata,
  output logic [63:0]   result
);

  logic [31:0] key_r [8];
  logic [63:0] sbox_r [8];
  logic [31:0] first_r, second_r;
  logic [31:0] src, sum, sub, rot;

  assign src = ctl.half_sel ? second_r : first_r;
  assign sum = src + key_r[ctl.key_idx];

  // row 0 substitutes the top nibble
  always_comb begin
    sub = '0;
    for (int row = 0; row < 8; row++) begin
      sub[28 - 4*row +: 4] = sbox_r[row][{sum[28 - 4*row +: 4], 2'b00} +: 4];
    end
  end

  assign rot    = {sub[31-gbc_pkg::ROT_AMOUNT:0], sub[31:32-gbc_pkg::ROT_AMOUNT]};
  assign result = {second_r, first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        key_r[i]  <= '0;
        sbox_r[i] <= '0;
      end
    end else begin
      if (cfg_we && !cfg_index[3]) key_r[cfg_index[2:0]] <= cfg_wdata;
      if (ctl.load_row) sbox_r[in_row_select] <= in_block_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_blk) begin
      first_r  <= in_block_in[63:32];
      second_r <= in_block_in[31:0];
    end else if (ctl.round_en) begin
      if (ctl.half_sel) first_r  <= first_r ^ rot;
      else              second_r <= second_r ^ rot;
    end
  end

endmodule
